// ===== design/tlm_pkg.sv =====
`timescale 1ns / 1ps

package tlm_pkg;

  // Width of the saturating sample counters.
  localparam int COUNT_BITS = 24;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int TEMP_W   = 13;
  localparam int TRIP_W   = 4;
  localparam int TOTAL_W  = 24;
  localparam int PCT_W    = 14;

  // The sum of valid samples needs 13 bits of headroom above the count.
  localparam int SUM_W  = COUNT_BITS + 13;
  localparam int PROD_W = COUNT_BITS + PCT_W;
  // Dividend width of the shared divider covers both the sum and the product.
  localparam int DVD_W  = PROD_W;
  localparam int BIT_W  = $clog2(DVD_W);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TEMP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_LIMIT = 1'b0,
    REG_TRIP_COUNT = 1'b1
  } cfg_reg_t;

  // Valid window is -50..150 degrees in 1/16 degree units.
  localparam logic signed [SAMPLE_W-1:0] TEMP_LOW  = -16'sd800;
  localparam logic signed [SAMPLE_W-1:0] TEMP_HIGH = 16'sd2400;
  localparam logic signed [TEMP_W-1:0]   MAX_RESET = -13'sd1600;
  localparam logic signed [TEMP_W-1:0]   MIN_RESET = 13'sd3200;
  localparam logic signed [TEMP_W-1:0]   LIMIT_RESET = 13'sd1280;
  localparam logic [TRIP_W-1:0]          TRIP_RESET  = 4'd3;
  localparam logic [TRIP_W-1:0]          RUN_MAX     = 4'd15;
  localparam logic [PCT_W-1:0]           PCT_SCALE   = 14'd10000;

endpackage

// ===== design/temperature_limit_monitor.sv =====
`timescale 1ns / 1ps

// Over-temperature monitor with a consecutive-sample trip.
// Input channel: in_valid/in_ready carry one item holding a signed sample in
// 1/16 degree units. Output channel: out_valid/out_ready carry one result item
// per input item with the flags, the run length, the trip state and the report
// fields (count, mean, peak, lowest, over count, over percentage).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_wdata. Index 0 is
// the limit, index 1 the trip count. cfg_ready is always high; write only while
// the block is idle.
// Processing: the item is captured, the statistics are updated, the percentage
// product is formed and the mean division is set up, then the shared
// restoring divider produces one quotient bit a cycle for the mean and then
// for the percentage, and the output register is loaded. The next item is
// taken only after the result has been loaded into the output register.
// When no valid sample has been seen the divisions are skipped. Reset (rst_n
// low, synchronous) clears the statistics, the trip latch and the output
// valid, and loads the limit 1280 and trip count 3.
// If the receiver stalls, the finished result waits in the output register;
// one more item can be accepted and processed, and its result then waits
// until the register is free.
module temperature_limit_monitor (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [tlm_pkg::SAMPLE_W-1:0]   in_sample_temp,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_reading_valid,
  output logic                                  out_over_limit,
  output logic [tlm_pkg::TRIP_W-1:0]            out_consecutive_over,
  output logic                                  out_tripped,
  output logic [tlm_pkg::TOTAL_W-1:0]           out_valid_total,
  output logic signed [tlm_pkg::TEMP_W-1:0]     out_mean_temp,
  output logic signed [tlm_pkg::TEMP_W-1:0]     out_peak_temp,
  output logic signed [tlm_pkg::TEMP_W-1:0]     out_lowest_temp,
  output logic [tlm_pkg::TOTAL_W-1:0]           out_over_total,
  output logic [tlm_pkg::PCT_W-1:0]             out_over_percent,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tlm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tlm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import tlm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  state_t state_r;

  // Configuration registers.
  logic signed [TEMP_W-1:0] temp_limit_r;
  logic [TRIP_W-1:0]        trip_count_r;

  // Monitor state.
  logic [COUNT_BITS-1:0]    valid_count_r;
  logic [COUNT_BITS-1:0]    over_count_r;
  logic signed [SUM_W-1:0]  temp_sum_r;
  logic signed [TEMP_W-1:0] max_seen_r;
  logic signed [TEMP_W-1:0] min_seen_r;
  logic [TRIP_W-1:0]        run_length_r;
  logic                     trip_r;

  // Item in flight.
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       valid_flag_r;
  logic                       over_flag_r;
  logic [PROD_W-1:0]          prod_r;
  logic signed [TEMP_W-1:0]   mean_res_r;
  logic [PCT_W-1:0]           pct_res_r;

  // Shared divider.
  logic [DVD_W-1:0]       quo_r;
  logic [COUNT_BITS-1:0]  rem_r;
  logic [BIT_W-1:0]       bit_cnt_r;
  logic                   pct_pass_r;
  logic                   sum_neg_r;

  // Output register.
  logic                     out_valid_r;
  logic                     out_reading_valid_r;
  logic                     out_over_limit_r;
  logic [TRIP_W-1:0]        out_consecutive_over_r;
  logic                     out_tripped_r;
  logic [TOTAL_W-1:0]       out_valid_total_r;
  logic signed [TEMP_W-1:0] out_mean_temp_r;
  logic signed [TEMP_W-1:0] out_peak_temp_r;
  logic signed [TEMP_W-1:0] out_lowest_temp_r;
  logic [TOTAL_W-1:0]       out_over_total_r;
  logic [PCT_W-1:0]         out_over_percent_r;

  // Per-sample update logic.
  logic                     in_range;
  logic                     take;
  logic                     above;
  logic signed [TEMP_W-1:0] samp13;
  logic [TRIP_W-1:0]        need;
  logic [TRIP_W-1:0]        run_inc;

  // Divider step and result shaping.
  logic [COUNT_BITS:0]      shifted;
  logic                     ge;
  logic [COUNT_BITS:0]      diff;
  logic [COUNT_BITS-1:0]    rem_nxt;
  logic [DVD_W-1:0]         quo_nxt;
  logic [SUM_W-1:0]         abs_sum;
  logic [TEMP_W-1:0]        q13;
  logic signed [TEMP_W-1:0] mean_nxt;
  logic [PCT_W-1:0]         pct_nxt;
  logic                     out_free;

  always_comb begin
    in_range = (sample_r >= TEMP_LOW) && (sample_r <= TEMP_HIGH);
    take     = !trip_r && in_range;
    above    = sample_r > SAMPLE_W'(temp_limit_r);
    samp13   = TEMP_W'(sample_r);
    need     = (trip_count_r == '0) ? TRIP_W'(1) : trip_count_r;
    run_inc  = (run_length_r < RUN_MAX) ? run_length_r + TRIP_W'(1) : run_length_r;

    shifted  = {rem_r, quo_r[DVD_W-1]};
    diff     = shifted - {1'b0, valid_count_r};
    ge       = shifted >= {1'b0, valid_count_r};
    rem_nxt  = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    quo_nxt  = {quo_r[DVD_W-2:0], ge};

    abs_sum  = temp_sum_r[SUM_W-1] ? SUM_W'(-temp_sum_r) : SUM_W'(temp_sum_r);
    q13      = quo_nxt[TEMP_W-1:0];
    mean_nxt = sum_neg_r ? TEMP_W'(-q13) : TEMP_W'(q13);
    pct_nxt  = (quo_nxt > DVD_W'(PCT_SCALE)) ? PCT_SCALE : quo_nxt[PCT_W-1:0];

    out_free = !out_valid_r || out_ready;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid            = out_valid_r;
  assign out_reading_valid    = out_reading_valid_r;
  assign out_over_limit       = out_over_limit_r;
  assign out_consecutive_over = out_consecutive_over_r;
  assign out_tripped          = out_tripped_r;
  assign out_valid_total      = out_valid_total_r;
  assign out_mean_temp        = out_mean_temp_r;
  assign out_peak_temp        = out_peak_temp_r;
  assign out_lowest_temp      = out_lowest_temp_r;
  assign out_over_total       = out_over_total_r;
  assign out_over_percent     = out_over_percent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      temp_limit_r  <= LIMIT_RESET;
      trip_count_r  <= TRIP_RESET;
      valid_count_r <= '0;
      over_count_r  <= '0;
      temp_sum_r    <= '0;
      max_seen_r    <= MAX_RESET;
      min_seen_r    <= MIN_RESET;
      run_length_r  <= '0;
      trip_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_TEMP_LIMIT: temp_limit_r <= cfg_wdata;
          REG_TRIP_COUNT: trip_count_r <= cfg_wdata[TRIP_W-1:0];
          default: ;
        endcase
      end

      // In S_FINISH the output register is reloaded instead.
      if (out_valid_r && out_ready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= in_sample_temp;
            state_r  <= S_UPDATE;
          end
        end

        S_UPDATE: begin
          // Apply the sample; after the trip the statistics are frozen.
          valid_flag_r <= take;
          over_flag_r  <= take && above;
          if (take) begin
            if (valid_count_r != CNT_MAX) begin
              valid_count_r <= valid_count_r + COUNT_BITS'(1);
              temp_sum_r    <= temp_sum_r + SUM_W'(sample_r);
            end
            if (samp13 > max_seen_r) begin
              max_seen_r <= samp13;
            end
            if (samp13 < min_seen_r) begin
              min_seen_r <= samp13;
            end
            if (above) begin
              if (over_count_r != CNT_MAX) begin
                over_count_r <= over_count_r + COUNT_BITS'(1);
              end
              run_length_r <= run_inc;
              if (run_inc >= need) begin
                trip_r <= 1'b1;
              end
            end else begin
              run_length_r <= '0;
            end
          end
          state_r <= S_MUL;
        end

        S_MUL: begin
          // Percentage product, then the mean division starts.
          prod_r     <= PROD_W'(over_count_r) * PROD_W'(PCT_SCALE);
          quo_r      <= DVD_W'(abs_sum);
          sum_neg_r  <= temp_sum_r[SUM_W-1];
          rem_r      <= '0;
          bit_cnt_r  <= '0;
          pct_pass_r <= 1'b0;
          if (valid_count_r == '0) begin
            mean_res_r <= '0;
            pct_res_r  <= '0;
            state_r    <= S_FINISH;
          end else begin
            state_r <= S_DIV;
          end
        end

        S_DIV: begin
          if (bit_cnt_r == BIT_W'(DVD_W - 1)) begin
            bit_cnt_r <= '0;
            if (!pct_pass_r) begin
              mean_res_r <= mean_nxt;
              quo_r      <= prod_r;
              rem_r      <= '0;
              pct_pass_r <= 1'b1;
            end else begin
              pct_res_r <= pct_nxt;
              state_r   <= S_FINISH;
            end
          end else begin
            quo_r     <= quo_nxt;
            rem_r     <= rem_nxt;
            bit_cnt_r <= bit_cnt_r + BIT_W'(1);
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_reading_valid_r    <= valid_flag_r;
            out_over_limit_r       <= over_flag_r;
            out_consecutive_over_r <= run_length_r;
            out_tripped_r          <= trip_r;
            out_valid_total_r      <= TOTAL_W'(valid_count_r);
            out_mean_temp_r        <= mean_res_r;
            out_peak_temp_r        <= max_seen_r;
            out_lowest_temp_r      <= min_seen_r;
            out_over_total_r       <= TOTAL_W'(over_count_r);
            out_over_percent_r     <= pct_res_r;
            state_r                <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The sequencer takes one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in work");

  // Once latched, the trip never clears until reset.
  a_trip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    trip_r |=> trip_r)
    else $error("trip latch cleared");

  // Over samples are a subset of valid samples.
  a_over_le_valid: assert property (@(posedge clk) disable iff (!rst_n)
    over_count_r <= valid_count_r)
    else $error("over count exceeds valid count");

  // A result flagged over limit must come from a valid sample.
  a_over_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_over_limit) |-> out_reading_valid)
    else $error("over limit without a valid reading");

  // The percentage never passes 100.00.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_over_percent <= PCT_SCALE))
    else $error("over percentage out of range");
`endif

endmodule
